[hw/rtl/ndedge_pkg.sv]
// Package for the neighbour-difference edge detector.
// Holds frame limits, payload structs, register indexes and output levels.
// No dependencies.
package ndedge_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 3);

  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int THR_W  = 10;
  localparam int DIM_W  = 11;
  localparam int SUM_W  = CH_W + 2;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam int THRESH_RESET = 64;
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  localparam logic [CH_W-1:0] LEVEL_EDGE = 8'd0;
  localparam logic [CH_W-1:0] LEVEL_BG   = 8'd255;

  typedef enum logic [1:0] {
    REG_THRESH = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            flush;
  } ndedge_in_t;

  typedef struct packed {
    logic            edge_res;
    logic [CH_W-1:0] level;
    logic            last_of_frame;
  } ndedge_out_t;

  typedef struct packed {
    logic left_ok;
    logic right_ok;
    logic up_ok;
    logic down_ok;
  } nbr_mask_t;

endpackage

[hw/rtl/neighbor_difference_edge_detect_unit.sv]
// Top level of the 3x3 neighbour-difference edge detector.
// Depends on ndedge_pkg, ndedge_ram and ndedge_cmp.
//
//   channel | direction | handshake                    | payload
//   in_     | in        | in_valid / in_stall          | ndedge_in_t  (red, green, blue, flush)
//   out_    | out       | out_valid / out_stall        | ndedge_out_t (edge_res, level, last)
//   cfg     | in        | psel/penable/pwrite, pready  | threshold, width, height
//
// One pixel transfer per cycle while out_stall does not hold the pipeline; the line-store
// read and stage 1 load at the transfer that completes a window, and the window compare
// and result register load when stage 1 fires.
// A result for a pixel appears one row plus one pixel after that pixel arrives.
// Synchronous reset clears counters, window and handshake state; line stores
// are not cleared. out_stall holds the result register and the stage behind it.
module neighbor_difference_edge_detect_unit import ndedge_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ndedge_in_t        in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ndedge_out_t       out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [THR_W-1:0] thresh_r;
  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;
  logic             cfg_wr;
  logic             geom_wr;

  logic [WID_W-1:0] eff_w;
  logic [HGT_W-1:0] eff_h;

  logic [COL_W-1:0] in_col_r, in_col_nxt;
  logic [ROW_W-1:0] in_row_r, in_row_nxt;
  logic [COL_W-1:0] out_col_r, out_col_nxt;
  logic [ROW_W-1:0] out_row_r, out_row_nxt;

  logic             accept;
  logic             in_frame;
  logic             drop;
  logic             s1_load;
  logic             emit;
  logic             last;
  nbr_mask_t        mask;
  logic [WID_W-1:0] col_inc;
  logic [WID_W-1:0] oc_inc;
  logic [ROW_W-1:0] or_inc;
  pixel_t           px;

  logic             s1_valid_r;
  pixel_t           s1_px_r;
  logic [COL_W-1:0] s1_col_r;
  logic             s1_emit_r;
  logic             s1_last_r;
  nbr_mask_t        s1_mask_r;
  logic             fire1;

  logic             byp_r;
  logic [2*PIX_W-1:0] byp_data_r;
  logic [2*PIX_W-1:0] ram_rdata;
  logic [2*PIX_W-1:0] rd;
  logic [2*PIX_W-1:0] wdata;

  pixel_t [8:0]     win_r, win_nxt;
  logic             edge_hit;

  logic             out_valid_r;
  ndedge_out_t      out_data_r;

  // configuration
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign geom_wr = cfg_wr && (paddr[3:2] == REG_WIDTH || paddr[3:2] == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THR_W'(THRESH_RESET);
      width_r  <= DIM_W'(WIDTH_RESET);
      height_r <= DIM_W'(HEIGHT_RESET);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_THRESH: thresh_r <= pwdata[THR_W-1:0];
        REG_WIDTH:  width_r  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_r <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_THRESH: prdata = DATA_W'(thresh_r);
      REG_WIDTH:  prdata = DATA_W'(width_r);
      REG_HEIGHT: prdata = DATA_W'(height_r);
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    priority if (width_r == '0) begin
      eff_w = WID_W'(1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      eff_w = WID_W'(MAX_WIDTH);
    end else begin
      eff_w = WID_W'(width_r);
    end
    priority if (height_r == '0) begin
      eff_h = HGT_W'(1);
    end else if (int'(height_r) > MAX_HEIGHT) begin
      eff_h = HGT_W'(MAX_HEIGHT);
    end else begin
      eff_h = HGT_W'(height_r);
    end
  end

  // input side: position tracking
  assign in_stall = s1_valid_r && !fire1;
  assign accept   = in_valid && !in_stall;
  assign in_frame = in_row_r < ROW_W'(eff_h);
  assign drop     = in_data.flush && in_frame;
  assign s1_load  = accept && !drop;
  assign px       = in_frame ? {in_data.red, in_data.green, in_data.blue} : '0;

  assign emit     = (in_row_r >= ROW_W'(2)) || (in_row_r == ROW_W'(1) && in_col_r != '0);
  assign col_inc  = WID_W'(in_col_r) + WID_W'(1);
  assign oc_inc   = WID_W'(out_col_r) + WID_W'(1);
  assign or_inc   = out_row_r + ROW_W'(1);
  assign mask.left_ok  = out_col_r != '0;
  assign mask.right_ok = oc_inc < eff_w;
  assign mask.up_ok    = out_row_r != '0;
  assign mask.down_ok  = or_inc < ROW_W'(eff_h);
  assign last     = emit && !mask.right_ok && !mask.down_ok;

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (geom_wr || (s1_load && last)) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (s1_load) begin
      if (emit) begin
        if (!mask.right_ok) begin
          out_col_nxt = '0;
          out_row_nxt = or_inc;
        end else begin
          out_col_nxt = COL_W'(oc_inc);
        end
      end
      if (col_inc >= eff_w) begin
        in_col_nxt = '0;
        if (in_row_r < ROW_W'(eff_h) + ROW_W'(2)) begin
          in_row_nxt = in_row_r + ROW_W'(1);
        end
      end else begin
        in_col_nxt = COL_W'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // line stores: upper row in the high half, middle row in the low half
  ndedge_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (fire1),
    .waddr (s1_col_r),
    .wdata (wdata),
    .re    (s1_load),
    .raddr (in_col_r),
    .rdata (ram_rdata)
  );

  // stage 1
  assign fire1 = s1_valid_r && (!out_valid_r || !out_stall || !s1_emit_r);
  assign rd    = byp_r ? byp_data_r : ram_rdata;
  assign wdata = {rd[PIX_W-1:0], s1_px_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      byp_r      <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= 1'b1;
        byp_r      <= fire1 && (s1_col_r == in_col_r);
      end else if (fire1) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_px_r    <= px;
      s1_col_r   <= in_col_r;
      s1_emit_r  <= emit;
      s1_last_r  <= last;
      s1_mask_r  <= mask;
      byp_data_r <= wdata;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r*3]   = win_r[r*3+1];
      win_nxt[r*3+1] = win_r[r*3+2];
    end
    win_nxt[2] = rd[2*PIX_W-1:PIX_W];
    win_nxt[5] = rd[PIX_W-1:0];
    win_nxt[8] = s1_px_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (fire1) begin
      win_r <= win_nxt;
    end
  end

  ndedge_cmp u_cmp (
    .win      (win_nxt),
    .mask     (s1_mask_r),
    .thresh   (thresh_r),
    .edge_hit (edge_hit)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire1 && s1_emit_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire1 && s1_emit_r) begin
      out_data_r.edge_res      <= edge_hit;
      out_data_r.level         <= edge_hit ? LEVEL_EDGE : LEVEL_BG;
      out_data_r.last_of_frame <= s1_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_last_r |-> in_col_r == '0 && in_row_r == '0 &&
                                out_col_r == '0 && out_row_r == '0)
    else $error("frame counters not restarted behind final pixel");

  a_row_cap: assert property (@(posedge clk) disable iff (!rst_n)
    in_row_r <= ROW_W'(eff_h) + ROW_W'(2))
    else $error("input row ran past frame height");

  a_out_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    WID_W'(out_col_r) < eff_w && WID_W'(in_col_r) < eff_w)
    else $error("column counter outside frame width");
`endif

endmodule

[hw/rtl/ndedge_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the two line stores of the edge detector.
module ndedge_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/ndedge_cmp.sv]
// Neighbour compare for one 3x3 window: summed RGB distance against threshold.
// Depends on ndedge_pkg.
module ndedge_cmp import ndedge_pkg::*; (
  input  pixel_t [8:0]     win,
  input  nbr_mask_t        mask,
  input  logic [THR_W-1:0] thresh,
  output logic             edge_hit
);

  function automatic logic [CH_W-1:0] absdiff(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [SUM_W-1:0] rgb_dist(input pixel_t a, input pixel_t b);
    logic [SUM_W-1:0] dr;
    logic [SUM_W-1:0] dg;
    logic [SUM_W-1:0] db;
    dr = SUM_W'(absdiff(a[PIX_W-1 -: CH_W], b[PIX_W-1 -: CH_W]));
    dg = SUM_W'(absdiff(a[2*CH_W-1 -: CH_W], b[2*CH_W-1 -: CH_W]));
    db = SUM_W'(absdiff(a[CH_W-1:0], b[CH_W-1:0]));
    return dr + dg + db;
  endfunction

  always_comb begin
    edge_hit = 1'b0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (!(r == 1 && c == 1) &&
            (c != 0 || mask.left_ok) && (c != 2 || mask.right_ok) &&
            (r != 0 || mask.up_ok) && (r != 2 || mask.down_ok) &&
            (rgb_dist(win[4], win[r*3+c]) > SUM_W'(thresh))) begin
          edge_hit = 1'b1;
        end
      end
    end
  end

endmodule

[verif/tb_neighbor_difference_edge_detect_unit.sv]
// Self-checking testbench for neighbor_difference_edge_detect_unit: raster frames with
// random stalls on both channels, APB register writes between and within frames, and a local
// prediction of edge/background levels. Depends on ndedge_pkg and the unit's RTL.
module tb_neighbor_difference_edge_detect_unit import ndedge_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEM_TARGET    = 520;
  localparam int unsigned SETTLE_CYCLES  = 12;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  typedef enum int {PAINT_NOISE, PAINT_SMOOTH, PAINT_TWO_TONE} paint_style_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  ndedge_in_t        in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  ndedge_out_t       out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  neighbor_difference_edge_detect_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  ndedge_in_t  pixel_queue[$];
  ndedge_out_t pending_levels[$];
  int unsigned errors = 0;
  int unsigned pixels_queued = 0;
  bit          send_eager = 1'b0;
  bit          recv_eager = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned hold_left = 0;
  int unsigned hold_req = 0;
  int unsigned hold_done = 0;
  int unsigned quiet_cycles = 0;
  bit [PIX_W-1:0] paint_base = '0;
  bit [PIX_W-1:0] tone_a = '0;
  bit [PIX_W-1:0] tone_b = '1;

  // Predictor state
  int unsigned    thresh_cfg = THRESH_RESET;
  int unsigned    width_cfg = WIDTH_RESET;
  int unsigned    height_cfg = HEIGHT_RESET;
  bit [PIX_W-1:0] upper_line[MAX_WIDTH];
  bit [PIX_W-1:0] middle_line[MAX_WIDTH];
  bit [PIX_W-1:0] win[9];
  int unsigned    feed_col = 0;
  int unsigned    feed_row = 0;
  int unsigned    centre_col = 0;
  int unsigned    centre_row = 0;

  function automatic int unsigned clamp_dim(int unsigned raw, int unsigned ceiling);
    if (raw == 0) return 1;
    if (raw > ceiling) return ceiling;
    return raw;
  endfunction

  function automatic int unsigned chan_gap(bit [CH_W-1:0] a, bit [CH_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int unsigned rgb_distance(bit [PIX_W-1:0] a, bit [PIX_W-1:0] b);
    return chan_gap(a[23:16], b[23:16]) + chan_gap(a[15:8], b[15:8])
         + chan_gap(a[7:0], b[7:0]);
  endfunction

  function automatic int unsigned pick_gap(bit eager);
    int unsigned roll;
    if (eager) return 0;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic restart_frame();
    feed_col = 0;
    feed_row = 0;
    centre_col = 0;
    centre_row = 0;
  endtask

  task automatic classify_step(ndedge_in_t item);
    int unsigned    w, h, col;
    bit             emit, is_edge, is_last;
    bit [PIX_W-1:0] px, up_px, mid_px;
    ndedge_out_t    res;
    w = clamp_dim(width_cfg, MAX_WIDTH);
    h = clamp_dim(height_cfg, MAX_HEIGHT);
    is_edge = 1'b0;
    is_last = 1'b0;
    if (item.flush && feed_row < h) return;
    px = (feed_row < h) ? {item.red, item.green, item.blue} : '0;
    col = feed_col % MAX_WIDTH;
    up_px = upper_line[col];
    mid_px = middle_line[col];
    upper_line[col] = mid_px;
    middle_line[col] = px;
    for (int r = 0; r < 3; r++) begin
      win[r*3] = win[r*3+1];
      win[r*3+1] = win[r*3+2];
      win[r*3+2] = '0;
    end
    if (feed_col != 0) begin
      win[2] = up_px;
      win[5] = mid_px;
      win[8] = px;
    end
    emit = feed_row >= 2 || (feed_row == 1 && feed_col >= 1);
    if (emit) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if (r == 1 && c == 1) continue;
          if (c == 0 && centre_col == 0) continue;
          if (c == 2 && centre_col + 1 >= w) continue;
          if (r == 0 && centre_row == 0) continue;
          if (r == 2 && centre_row + 1 >= h) continue;
          if (rgb_distance(win[4], win[r*3+c]) > thresh_cfg) is_edge = 1'b1;
        end
      end
      is_last = centre_col + 1 >= w && centre_row + 1 >= h;
      res.edge_res = is_edge;
      res.level = is_edge ? LEVEL_EDGE : LEVEL_BG;
      res.last_of_frame = is_last;
      pending_levels.push_back(res);
    end
    if (feed_col == 0) begin
      win[2] = up_px;
      win[5] = mid_px;
      win[8] = px;
    end
    if (is_last) begin
      restart_frame();
    end else begin
      if (emit) begin
        centre_col++;
        if (centre_col >= w) begin
          centre_col = 0;
          centre_row++;
        end
      end
      feed_col++;
      if (feed_col >= w) begin
        feed_col = 0;
        if (feed_row < h + 2) feed_row++;
      end
    end
  endtask

  always @(posedge clk) begin : pixel_feed
    bit busy;
    busy = in_valid;
    if (in_valid && !in_stall) begin
      classify_step(in_data);
      busy = 1'b0;
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!busy) begin
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pixel_queue.size() != 0) begin
        in_data <= pixel_queue.pop_front();
        in_valid <= 1'b1;
        send_gap <= pick_gap(send_eager);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : level_check
    ndedge_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_levels.size() == 0) begin
        $error("result transfer with no result expected");
        errors++;
      end else begin
        want = pending_levels.pop_front();
        if (out_data.edge_res !== want.edge_res) begin
          $error("edge_res: expected %0d, got %0d", want.edge_res, out_data.edge_res);
          errors++;
        end
        if (out_data.level !== want.level) begin
          $error("level: expected %0d, got %0d", want.level, out_data.level);
          errors++;
        end
        if (out_data.last_of_frame !== want.last_of_frame) begin
          $error("last_of_frame: expected %0d, got %0d", want.last_of_frame,
                 out_data.last_of_frame);
          errors++;
        end
      end
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_done != hold_req) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD;
      hold_done <= hold_done + 1;
    end else if (recv_gap != 0) begin
      out_stall <= 1'b1;
      recv_gap <= recv_gap - 1;
    end else begin
      out_stall <= 1'b0;
      recv_gap <= pick_gap(recv_eager);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("neighbor_difference_edge_detect_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic check_reg(reg_idx_t idx, int unsigned want);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== DATA_W'(want)) begin
      $error("register %s: expected %0d, got %0d", idx.name(), want, prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_reg(reg_idx_t idx, int unsigned value);
    int unsigned masked;
    masked = (idx == REG_THRESH) ? value % (1 << THR_W) : value % (1 << DIM_W);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= DATA_W'(masked);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_THRESH: thresh_cfg = masked;
      REG_WIDTH: begin
        width_cfg = masked;
        restart_frame();
      end
      REG_HEIGHT: begin
        height_cfg = masked;
        restart_frame();
      end
      default: ;
    endcase
    check_reg(idx, masked);
  endtask

  task automatic wait_for_idle();
    do begin
      do @(posedge clk);
      while (pixel_queue.size() != 0 || in_valid || pending_levels.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end while (pixel_queue.size() != 0 || in_valid || pending_levels.size() != 0);
  endtask

  function automatic ndedge_in_t paint_pixel(paint_style_t style);
    ndedge_in_t     p;
    bit [PIX_W-1:0] rgb;
    case (style)
      PAINT_NOISE: rgb = PIX_W'($urandom);
      PAINT_SMOOTH: begin
        if ($urandom_range(15) == 0) paint_base = PIX_W'($urandom);
        rgb = paint_base ^ {4'd0, 4'($urandom), 4'd0, 4'($urandom), 4'd0, 4'($urandom)};
      end
      default: rgb = ($urandom_range(3) == 0) ? tone_b : tone_a;
    endcase
    {p.red, p.green, p.blue} = rgb;
    p.flush = 1'b0;
    return p;
  endfunction

  task automatic queue_colour(bit [PIX_W-1:0] rgb);
    ndedge_in_t item;
    {item.red, item.green, item.blue} = rgb;
    item.flush = 1'b0;
    pixel_queue.push_back(item);
    pixels_queued++;
  endtask

  task automatic queue_flush();
    ndedge_in_t item;
    {item.red, item.green, item.blue} = PIX_W'($urandom);
    item.flush = 1'b1;
    pixel_queue.push_back(item);
  endtask

  task automatic queue_pixels(int unsigned count, paint_style_t style, bit noisy);
    repeat (count) begin
      // drop an early flush in now and then; the unit ignores it
      if (noisy && $urandom_range(9) == 0) queue_flush();
      pixel_queue.push_back(paint_pixel(style));
      pixels_queued++;
    end
  endtask

  task automatic queue_drain(bit noisy);
    repeat (clamp_dim(width_cfg, MAX_WIDTH) + 1) begin
      if (noisy && $urandom_range(5) == 0) begin
        pixel_queue.push_back(paint_pixel(PAINT_NOISE));
        pixels_queued++;
      end else begin
        queue_flush();
        pixels_queued++;
      end
    end
  endtask

  task automatic run_frame(paint_style_t style, bit noisy);
    queue_pixels(clamp_dim(width_cfg, MAX_WIDTH) * clamp_dim(height_cfg, MAX_HEIGHT),
                 style, noisy);
    queue_drain(noisy);
  endtask

  initial begin
    int unsigned  area, split, phase;
    paint_style_t style;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_reg(REG_THRESH, THRESH_RESET);
    check_reg(REG_WIDTH, WIDTH_RESET);
    check_reg(REG_HEIGHT, HEIGHT_RESET);

    // 3x3 frame: colour extremes, an early flush, an extra pixel while draining
    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 3);
    queue_colour(24'h000000);
    queue_colour(24'hFFFFFF);
    queue_colour(24'h000000);
    queue_flush();
    queue_colour(24'hAA55AA);
    queue_colour(24'h55AA55);
    queue_colour(24'h202020);
    queue_colour(24'h212020);
    queue_colour(24'h202040);
    queue_colour(24'h7F807F);
    queue_flush();
    queue_colour(24'hFF00FF);
    queue_flush();
    queue_flush();
    wait_for_idle();

    // single row: sums of exactly the threshold and one above it
    write_reg(REG_HEIGHT, 1);
    queue_colour(24'h78787C);
    queue_colour(24'h646464);
    queue_colour(24'h6464A5);
    repeat (4) queue_flush();
    wait_for_idle();

    // zero geometry behaves as one pixel
    write_reg(REG_WIDTH, 0);
    write_reg(REG_HEIGHT, 0);
    queue_colour(24'h123456);
    repeat (2) queue_flush();
    wait_for_idle();

    // hold the result side for a long stretch while pixels keep coming
    write_reg(REG_THRESH, $urandom_range(150, 30));
    write_reg(REG_WIDTH, 16);
    write_reg(REG_HEIGHT, 8);
    send_eager = 1'b1;
    recv_eager = 1'b0;
    run_frame(PAINT_SMOOTH, 1'b0);
    hold_req++;
    wait_for_idle();

    phase = 0;
    while (pixels_queued < ITEM_TARGET) begin
      case (phase % 5)
        0: write_reg(REG_THRESH, 0);
        1: write_reg(REG_THRESH, (1 << THR_W) - 1);
        2: write_reg(REG_THRESH, 765);
        3: write_reg(REG_THRESH, 766);
        default: write_reg(REG_THRESH, $urandom_range(300, 10));
      endcase
      case ($urandom_range(7))
        0: write_reg(REG_WIDTH, 0);
        1: write_reg(REG_WIDTH, 1);
        2: write_reg(REG_WIDTH, 2);
        default: write_reg(REG_WIDTH, $urandom_range(12, 3));
      endcase
      write_reg(REG_HEIGHT, ($urandom_range(7) == 0) ? 0 : $urandom_range(6, 1));
      send_eager = ($urandom_range(3) == 0);
      recv_eager = ($urandom_range(3) == 0);
      tone_a = PIX_W'($urandom);
      tone_b = PIX_W'($urandom);
      style = paint_style_t'($urandom_range(2));
      area = clamp_dim(width_cfg, MAX_WIDTH) * clamp_dim(height_cfg, MAX_HEIGHT);
      case ($urandom_range(7))
        0: begin
          // abandon the frame part way; a geometry write restarts it
          queue_pixels($urandom_range(area), style, 1'b1);
          wait_for_idle();
          write_reg(REG_HEIGHT, height_cfg);
          run_frame(style, 1'b0);
        end
        1: begin
          // pause mid-frame until drained, then move the threshold
          split = $urandom_range(area);
          queue_pixels(split, style, 1'b0);
          wait_for_idle();
          write_reg(REG_THRESH, $urandom_range(200, 5));
          queue_pixels(area - split, style, 1'b0);
          queue_drain(1'b0);
        end
        default: begin
          repeat ($urandom_range(2, 1)) run_frame(style, $urandom_range(2) == 0);
        end
      endcase
      wait_for_idle();
      phase++;
    end

    // widest and tallest register values, then width one; each from the start of a frame
    send_eager = 1'b0;
    recv_eager = 1'b0;
    write_reg(REG_THRESH, $urandom_range(120, 20));
    write_reg(REG_WIDTH, (1 << DIM_W) - 1);
    write_reg(REG_HEIGHT, (1 << DIM_W) - 1);
    queue_pixels(24, PAINT_SMOOTH, 1'b1);
    wait_for_idle();
    tone_a = PIX_W'($urandom);
    tone_b = PIX_W'($urandom);
    write_reg(REG_WIDTH, 1);
    queue_pixels(48, PAINT_TWO_TONE, 1'b1);
    wait_for_idle();

    while (pending_levels.size() != 0) begin
      void'(pending_levels.pop_front());
      $error("expected result never arrived");
      errors++;
    end
    if (errors == 0) begin
      $display("neighbor_difference_edge_detect_unit regression: pass");
    end else begin
      $display("neighbor_difference_edge_detect_unit regression: fail");
    end
    $finish;
  end

endmodule
